>>> hw/rtl/fcpq_pkg.sv
// ----------------------------------------------------------------------------
// fcpq_pkg: shared types and constants of the four-class frame queue
// Holds the function and status codes, the stored frame layout, the
// controller states and the command and status bundles between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package fcpq_pkg;

    // Number of priority classes and fixed field widths.
    localparam int NUM_CLASSES  = 4;
    localparam int CLASS_W      = 2;
    localparam int IDENT_W      = 29;
    localparam int LENGTH_W     = 4;
    localparam int PAYLOAD_W    = 64;
    localparam int LIMIT_W      = 5;
    localparam int COUNT32_W    = 32;
    localparam int PENDING_W    = 7;
    localparam int CFG_ADDR_W   = 2;

    // Stream widths: fields packed from bit 0 and padded to whole bytes.
    localparam int IN_TDATA_W   = 104;
    localparam int IN_TUSER_W   = 4;
    localparam int OUT_TDATA_W  = 208;
    localparam int OUT_TUSER_W  = 3;
    localparam int OUT_PAD_W    = 4;

    // Reset value of each class limit.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_CONTROL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_RECOVER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_SETUP   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT_QUERY   = 2'd3;

    // Request kinds carried on the input stream.
    typedef enum logic [1:0] {
        FN_SUBMIT = 2'd0,
        FN_SEND   = 2'd1,
        FN_STOP   = 2'd2,
        FN_START  = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DROP_FULL = 3'd1,
        ST_DROP_STOP = 3'd2,
        ST_SENT      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_DONE      = 3'd5
    } status_t;

    // One stored frame.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [LENGTH_W-1:0]  length;
        logic [IDENT_W-1:0]   ident;
    } frame_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_LOAD = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/fcpq_ctrl.sv
// ----------------------------------------------------------------------------
// fcpq_ctrl: sequencing controller of the frame queue
// Steps each accepted transaction through capture, execute and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fcpq_pkg::sts_t sts,
    output fcpq_pkg::cmd_t     cmd
);

    fcpq_pkg::state_t state_reg;
    fcpq_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            fcpq_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = fcpq_pkg::S_EXEC;
                end
            end
            fcpq_pkg::S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = fcpq_pkg::S_LOAD;
            end
            fcpq_pkg::S_LOAD:
            begin
                // Wait until the output register can take the result.
                cmd.load = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = fcpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/fcpq_dpath.sv
// ----------------------------------------------------------------------------
// fcpq_dpath: datapath of the frame queue
// Holds the frame memory, queue pointers, counters, limits and the output
// register, and performs submit, send, stop and start on command.
// ----------------------------------------------------------------------------
`default_nettype none

module fcpq_dpath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire fcpq_pkg::cmd_t                        cmd,
    output fcpq_pkg::sts_t                             sts,
    input  wire logic                                  cfg_write,
    input  wire logic [fcpq_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [fcpq_pkg::LIMIT_W-1:0]          cfg_data,
    input  wire logic [fcpq_pkg::IN_TDATA_W-1:0]       in_tdata,
    input  wire logic [fcpq_pkg::IN_TUSER_W-1:0]       in_tuser,
    output logic                                       out_tvalid,
    input  wire logic                                  out_tready,
    output logic [fcpq_pkg::OUT_TDATA_W-1:0]           out_tdata,
    output logic [fcpq_pkg::OUT_TUSER_W-1:0]           out_tuser
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = fcpq_pkg::NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(MEM_DEPTH);
    localparam int CMP_W  = (CNT_W > fcpq_pkg::LIMIT_W) ? CNT_W : fcpq_pkg::LIMIT_W;
    localparam int SUM_W  = (CNT_W + 2 > fcpq_pkg::PENDING_W) ? CNT_W + 2
                                                               : fcpq_pkg::PENDING_W;
    localparam int NC     = fcpq_pkg::NUM_CLASSES;

    // Frame memory, shared by all four classes.
    fcpq_pkg::frame_t mem [MEM_DEPTH];

    // Configuration and queue state.
    logic [fcpq_pkg::LIMIT_W-1:0]   limit_reg  [NC];
    logic [PTR_W-1:0]               head_reg   [NC];
    logic [CNT_W-1:0]               fill_reg   [NC];
    logic [fcpq_pkg::COUNT32_W-1:0] drop_reg   [NC];
    logic [fcpq_pkg::COUNT32_W-1:0] submit_cnt_reg;
    logic [fcpq_pkg::COUNT32_W-1:0] send_cnt_reg;
    logic                           stop_reg;
    logic                           started_reg;

    // Captured transaction and execute results.
    fcpq_pkg::func_t                in_func_reg;
    logic [fcpq_pkg::CLASS_W-1:0]   in_class_reg;
    fcpq_pkg::frame_t               in_frame_reg;
    fcpq_pkg::status_t              status_reg;
    fcpq_pkg::status_t              status_next;
    logic [fcpq_pkg::CLASS_W-1:0]   sent_class_reg;
    logic                           sent_flag_reg;
    fcpq_pkg::frame_t               rd_reg;

    // Output register.
    logic                             out_valid_reg;
    logic [fcpq_pkg::OUT_TDATA_W-1:0] out_tdata_reg;
    logic [fcpq_pkg::OUT_TUSER_W-1:0] out_tuser_reg;
    logic [fcpq_pkg::OUT_TDATA_W-1:0] out_tdata_next;

    // Execute-stage decode.
    logic [CMP_W-1:0]           lim_ext;
    logic [CMP_W-1:0]           lim_eff;
    logic                       is_full;
    logic [PTR_W:0]             slot_sum;
    logic [PTR_W-1:0]           tail_slot;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          rd_addr;
    logic                       found;
    logic [fcpq_pkg::CLASS_W-1:0] win;
    logic [PTR_W-1:0]           win_head_next;
    logic                       do_accept;
    logic                       do_drop;
    logic                       do_send;

    // Result-stage summary.
    logic [SUM_W-1:0]           pend_sum;
    logic                       all_empty;
    logic                       running;
    fcpq_pkg::frame_t           sent_frame;

    assign sts.out_free = !out_valid_reg || out_tready;
    assign out_tvalid   = out_valid_reg;
    assign out_tdata    = out_tdata_reg;
    assign out_tuser    = out_tuser_reg;

    // Submit path: effective limit, full check and tail address.
    always_comb
    begin
        lim_ext  = CMP_W'(limit_reg[in_class_reg]);
        lim_eff  = (lim_ext > CMP_W'(QUEUE_DEPTH)) ? CMP_W'(QUEUE_DEPTH) : lim_ext;
        is_full  = CMP_W'(fill_reg[in_class_reg]) >= lim_eff;
        slot_sum = {1'b0, head_reg[in_class_reg]} + (PTR_W + 1)'(fill_reg[in_class_reg]);
        if (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
        begin
            slot_sum = slot_sum - (PTR_W + 1)'(QUEUE_DEPTH);
        end
        tail_slot = slot_sum[PTR_W-1:0];
        wr_addr   = ADDR_W'(in_class_reg * QUEUE_DEPTH) + ADDR_W'(tail_slot);
    end

    // Send path: fixed-priority pick of the first non-empty class.
    always_comb
    begin
        found = 1'b1;
        win   = '0;
        priority if (fill_reg[0] != '0)
        begin
            win = 2'd0;
        end
        else if (fill_reg[1] != '0)
        begin
            win = 2'd1;
        end
        else if (fill_reg[2] != '0)
        begin
            win = 2'd2;
        end
        else if (fill_reg[3] != '0)
        begin
            win = 2'd3;
        end
        else
        begin
            found = 1'b0;
        end
        rd_addr = ADDR_W'(win * QUEUE_DEPTH) + ADDR_W'(head_reg[win]);
        win_head_next = (head_reg[win] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : head_reg[win] + 1'b1;
    end

    // Outcome of the captured transaction.
    always_comb
    begin
        do_accept   = 1'b0;
        do_drop     = 1'b0;
        do_send     = 1'b0;
        status_next = fcpq_pkg::ST_DONE;
        unique case (in_func_reg)
            fcpq_pkg::FN_SUBMIT:
            begin
                if (stop_reg)
                begin
                    do_drop     = 1'b1;
                    status_next = fcpq_pkg::ST_DROP_STOP;
                end
                else if (is_full)
                begin
                    do_drop     = 1'b1;
                    status_next = fcpq_pkg::ST_DROP_FULL;
                end
                else
                begin
                    do_accept   = 1'b1;
                    status_next = fcpq_pkg::ST_ACCEPTED;
                end
            end
            fcpq_pkg::FN_SEND:
            begin
                do_send     = found;
                status_next = found ? fcpq_pkg::ST_SENT : fcpq_pkg::ST_EMPTY;
            end
            fcpq_pkg::FN_STOP,
            fcpq_pkg::FN_START:
            begin
                status_next = fcpq_pkg::ST_DONE;
            end
            default:
            begin
                status_next = fcpq_pkg::ST_DONE;
            end
        endcase
    end

    // Frame memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_accept)
        begin
            mem[wr_addr] <= in_frame_reg;
        end
        if (cmd.exec)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // Captured transaction payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_frame_reg.ident   <= in_tdata[28:0];
            in_frame_reg.length  <= in_tdata[32:29];
            in_frame_reg.payload <= in_tdata[96:33];
            in_class_reg         <= in_tuser[3:2];
            in_func_reg          <= fcpq_pkg::func_t'(in_tuser[1:0]);
        end
        if (cmd.exec)
        begin
            status_reg     <= status_next;
            sent_class_reg <= do_send ? win : '0;
            sent_flag_reg  <= do_send;
        end
    end

    // Limits, queue pointers, counters and run flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NC; c++)
            begin
                limit_reg[c] <= fcpq_pkg::LIMIT_RESET;
                head_reg[c]  <= '0;
                fill_reg[c]  <= '0;
                drop_reg[c]  <= '0;
            end
            submit_cnt_reg <= '0;
            send_cnt_reg   <= '0;
            stop_reg       <= 1'b0;
            started_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                limit_reg[cfg_addr] <= cfg_data;
            end
            if (cmd.exec)
            begin
                if (do_accept)
                begin
                    fill_reg[in_class_reg] <= fill_reg[in_class_reg] + 1'b1;
                    submit_cnt_reg         <= submit_cnt_reg + 1'b1;
                end
                if (do_drop)
                begin
                    drop_reg[in_class_reg] <= drop_reg[in_class_reg] + 1'b1;
                end
                if (do_send)
                begin
                    fill_reg[win] <= fill_reg[win] - 1'b1;
                    head_reg[win] <= win_head_next;
                    send_cnt_reg  <= send_cnt_reg + 1'b1;
                end
                if (in_func_reg == fcpq_pkg::FN_STOP)
                begin
                    stop_reg <= 1'b1;
                end
                if (in_func_reg == fcpq_pkg::FN_START)
                begin
                    stop_reg    <= 1'b0;
                    started_reg <= 1'b1;
                end
            end
        end
    end

    // Result assembly from the updated state.
    always_comb
    begin
        pend_sum = '0;
        for (int c = 0; c < NC; c++)
        begin
            pend_sum = pend_sum + SUM_W'(fill_reg[c]);
        end
        all_empty  = (pend_sum == '0);
        running    = started_reg && !stop_reg;
        sent_frame = sent_flag_reg ? rd_reg : '0;
        out_tdata_next = {
            {fcpq_pkg::OUT_PAD_W{1'b0}},
            running,
            all_empty,
            pend_sum[fcpq_pkg::PENDING_W-1:0],
            drop_reg[in_class_reg],
            send_cnt_reg,
            submit_cnt_reg,
            sent_frame.payload,
            sent_frame.length,
            sent_frame.ident,
            sent_class_reg
        };
    end

    // Output register: control part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload part.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_tdata_reg <= out_tdata_next;
            out_tuser_reg <= status_reg;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/four_class_priority_frame_queue_core.sv
// Each accepted transaction is captured, executed with the frame memory read
// and its result loaded; a new one is taken only after that load. The result
// register overlaps the next transaction, and the load waits while an earlier
// result is still held by the result side.
// Reset: rst_n clears queues, counters and stop; limits return to 16 and the
// block comes up running. Frame memory contents are not cleared.
// ----------------------------------------------------------------------------
// four_class_priority_frame_queue_core: strict-priority four-class frame queue
// Tail-drop FIFOs for control, recover, config and query frames with a
// fixed-priority send, stop and start, and per-class drop counters.
// ----------------------------------------------------------------------------
`default_nettype none

module four_class_priority_frame_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration write channel.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [fcpq_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [fcpq_pkg::LIMIT_W-1:0]          cfg_data,
    // Input stream.
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // frame_ident[28:0], frame_length[32:29], frame_payload[96:33], zero pad
    input  wire logic [fcpq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // func[1:0], frame_class[3:2]
    input  wire logic [fcpq_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // Output stream.
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // sent_class[1:0], sent_ident[30:2], sent_length[34:31],
    // sent_payload[98:35], submitted_total[130:99], sent_total[162:131],
    // dropped_in_class[194:163], pending_total[201:195], all_empty[202],
    // running[203], zero pad
    output logic [fcpq_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    // status[2:0]
    output logic [fcpq_pkg::OUT_TUSER_W-1:0]           m_axis_tuser
);

    fcpq_pkg::cmd_t cmd;
    fcpq_pkg::sts_t sts;

    // Limits are plain registers and can always be written.
    assign cfg_ready = 1'b1;

    fcpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fcpq_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_write  (cfg_valid),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .in_tuser   (s_axis_tuser),
        .out_tvalid (m_axis_tvalid),
        .out_tready (m_axis_tready),
        .out_tdata  (m_axis_tdata),
        .out_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire
